FILE: sv/att_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// att_pkg: shared types and constants for the text terminal
// Payload structs, palette table and default sizes.
// ----------------------------------------------------------------------------
package att_pkg;

  localparam int unsigned COLUMNS_DEF     = 80;
  localparam int unsigned ROWS_DEF        = 25;
  localparam int unsigned PARAM_DEPTH_DEF = 15;

  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_BEL   = 8'h07;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_M     = 8'h6D;
  localparam logic [7:0] CH_J     = 8'h4A;
  localparam logic [7:0] FINAL_LO = 8'h40;
  localparam logic [7:0] FINAL_HI = 8'h7E;

  localparam logic CFG_FG = 1'b0;
  localparam logic CFG_BG = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
    logic [4:0] read_row;
    logic [6:0] read_column;
  } in_item_t;

  typedef struct packed {
    logic        wrote_cell;
    logic [15:0] written_word;
    logic [4:0]  written_row;
    logic [6:0]  written_column;
    logic        scrolled;
    logic        cleared;
    logic        beep;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_column;
    logic [15:0] read_word;
  } out_item_t;

  function automatic logic [3:0] palette(input logic [3:0] idx);
    logic [3:0] r;
    case (idx)
      4'd0: r = 4'd0;    4'd1: r = 4'd4;    4'd2: r = 4'd2;    4'd3: r = 4'd6;
      4'd4: r = 4'd1;    4'd5: r = 4'd5;    4'd6: r = 4'd3;    4'd7: r = 4'd7;
      4'd8: r = 4'd8;    4'd9: r = 4'd12;   4'd10: r = 4'd10;  4'd11: r = 4'd14;
      4'd12: r = 4'd9;   4'd13: r = 4'd13;  4'd14: r = 4'd11;  default: r = 4'd15;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: sv/att_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// att_ram: character cell memory
// One write port and one registered read port.
// ----------------------------------------------------------------------------
module att_ram #(
  parameter int unsigned DEPTH = 2000,
  parameter int unsigned AW    = 11
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [15:0]   wdata,
  input  wire logic [AW-1:0] raddr,
  output logic [15:0]        rdata
);

  logic [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: sv/ansi_text_terminal.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ansi_text_terminal: byte-stream text terminal with its own cell RAM
// Interprets control bytes, printable text and CSI colour/clear sequences.
// ----------------------------------------------------------------------------
// Use: feed words on the in_ channel (cmd 0 = terminal byte, cmd 1 = read a
// cell). Every input word yields exactly one word on the out_ channel, held
// in an output register until out_ready takes it.
// An ordinary byte passes through S_BYTE and S_OUT, a read through S_RD,
// S_RDW and S_OUT, as the RAM read port is registered; in_ready is
// high only in S_IDLE, so a word is taken only once the last is through.
// A scroll walks the screen one cell per read and write pair and then
// blanks the last row. A clear writes every cell once. A CSI final byte
// m or J scans the buffered parameter bytes one per cycle; J stops at a ;.
// After reset the block runs a clearing pass over every cell that
// fills the RAM with spaces in colours 7 on 0; in_ready stays low meanwhile
// while configuration writes are taken at any time outside reset. When the
// receiver stalls, the result waits in the output register; one more word
// can be taken and worked on, and the sequencer then waits for the register.
// ----------------------------------------------------------------------------
module ansi_text_terminal #(
  parameter int unsigned COLUMNS     = att_pkg::COLUMNS_DEF,
  parameter int unsigned ROWS        = att_pkg::ROWS_DEF,
  parameter int unsigned PARAM_DEPTH = att_pkg::PARAM_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire att_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output att_pkg::out_item_t     out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic              cfg_index,
  input  wire logic [3:0]        cfg_wdata
);

  localparam int unsigned CELLS = ROWS * COLUMNS;
  localparam int unsigned AW    = $clog2(CELLS + 1);
  localparam int unsigned CW    = $clog2(COLUMNS);
  localparam int unsigned RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned PW    = $clog2(PARAM_DEPTH + 1);
  localparam int unsigned PIW   = $clog2(PARAM_DEPTH);

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_RD     = 4'd2;
  localparam logic [3:0] S_RDW    = 4'd3;
  localparam logic [3:0] S_BYTE   = 4'd4;
  localparam logic [3:0] S_SCRR   = 4'd5;
  localparam logic [3:0] S_SCRW   = 4'd6;
  localparam logic [3:0] S_FILL   = 4'd7;
  localparam logic [3:0] S_SCAN   = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;
  localparam logic [3:0] S_OUT    = 4'd10;

  logic [3:0]    state_r, state_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [3:0]    fg_r, fg_nxt, bg_r, bg_nxt, dfg_r, dbg_r;
  logic          esc_r, esc_nxt, csi_r, csi_nxt;
  logic [PW-1:0] pcnt_r, pcnt_nxt, pidx_r, pidx_nxt;
  logic [7:0]    pbuf [PARAM_DEPTH];
  logic          pwe;
  logic [7:0]    code_r, code_nxt;
  logic          has_r, has_nxt, bad_r, bad_nxt, jdone_r, jdone_nxt;
  logic          fill_home_r, fill_home_nxt;
  att_pkg::in_item_t  item_r;
  att_pkg::out_item_t res_r, res_nxt, out_r;
  logic          ovalid_r, ovalid_nxt;
  logic          ld_out;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [15:0]   wdata, rdata;
  logic [7:0]    b, pb;
  logic [11:0]   lin;
  logic [8:0]    dv;
  logic [7:0]    dsat;
  logic [3:0]    sfg, sbg;
  logic          do_sgr;
  logic [7:0]    sgr_code;

  att_ram #(.DEPTH(CELLS), .AW(AW)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = rst_n;
  assign out_valid = ovalid_r;
  assign out_data  = out_r;
  assign b         = item_r.data_byte;
  assign pb        = pbuf[pidx_r[PIW-1:0]];
  assign lin       = 12'(row_r) * 12'(COLUMNS) + 12'(col_r);
  assign dv        = 9'(code_r) * 9'd10 + 9'(pb - 8'h30);
  assign dsat      = ((code_r > 8'd25) || (dv > 9'd255)) ? 8'hFF : dv[7:0];

  // SGR decode of one code against the current colours.
  always_comb begin
    sfg = fg_r;
    sbg = bg_r;
    if (sgr_code == 8'd0 || sgr_code == 8'd27) begin
      sfg = dfg_r; sbg = dbg_r;
    end else if (sgr_code == 8'd7) begin
      sfg = bg_r;  sbg = fg_r;
    end else if (sgr_code >= 8'd30 && sgr_code <= 8'd37) begin
      sfg = att_pkg::palette(4'(sgr_code - 8'd30));
    end else if (sgr_code >= 8'd40 && sgr_code <= 8'd47) begin
      sbg = att_pkg::palette(4'(sgr_code - 8'd40));
    end else if (sgr_code >= 8'd90 && sgr_code <= 8'd97) begin
      sfg = att_pkg::palette(4'(sgr_code - 8'd82));
    end else if (sgr_code >= 8'd100 && sgr_code <= 8'd107) begin
      sbg = att_pkg::palette(4'(sgr_code - 8'd92));
    end
  end

  always_ff @(posedge clk) begin
    if (pwe) begin
      pbuf[pcnt_r[PIW-1:0]] <= b;
    end
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
    res_r <= res_nxt;
    if (ld_out) begin
      out_r <= res_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;  addr_nxt = addr_r;  col_nxt = col_r;  row_nxt = row_r;
    fg_nxt = fg_r;  bg_nxt = bg_r;  esc_nxt = esc_r;  csi_nxt = csi_r;
    pcnt_nxt = pcnt_r;  pidx_nxt = pidx_r;  code_nxt = code_r;
    has_nxt = has_r;  bad_nxt = bad_r;  jdone_nxt = jdone_r;
    fill_home_nxt = fill_home_r;
    res_nxt = res_r;  ovalid_nxt = ovalid_r;  ld_out = 1'b0;
    we = 1'b0;  waddr = addr_r;  wdata = {bg_r, fg_r, att_pkg::CH_SPACE};
    raddr = addr_r;  pwe = 1'b0;  do_sgr = 1'b0;  sgr_code = code_r;
    if (ovalid_r && out_ready) begin
      ovalid_nxt = 1'b0;
    end
    case (state_r)
      S_INIT: begin
        we = 1'b1;
        wdata = 16'h0720;
        addr_nxt = addr_r + AW'(1);
        if (addr_r == AW'(CELLS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          res_nxt = '0;
          state_nxt = in_data.cmd ? S_RD : S_BYTE;
          addr_nxt = AW'(12'(in_data.read_row) * 12'(COLUMNS) + 12'(in_data.read_column));
        end
      end
      S_RD: begin
        state_nxt = S_RDW;
      end
      S_RDW: begin
        if (32'(item_r.read_row) < ROWS && 32'(item_r.read_column) < COLUMNS) begin
          res_nxt.read_word = rdata;
        end
        state_nxt = S_OUT;
      end
      S_BYTE: begin
        state_nxt = S_OUT;
        if (b == att_pkg::CH_LBRK && esc_r) begin
          csi_nxt = 1'b1; esc_nxt = 1'b0; pcnt_nxt = '0;
        end else if (b == att_pkg::CH_ESC) begin
          esc_nxt = 1'b1;
        end else begin
          esc_nxt = 1'b0;
          if (csi_r) begin
            if (b >= att_pkg::FINAL_LO && b <= att_pkg::FINAL_HI) begin
              csi_nxt = 1'b0;
              pidx_nxt = '0; code_nxt = '0; has_nxt = 1'b0; bad_nxt = 1'b0;
              jdone_nxt = 1'b0;
              if (b == att_pkg::CH_M && pcnt_r == '0) begin
                fg_nxt = dfg_r; bg_nxt = dbg_r;
              end else if (b == att_pkg::CH_M || b == att_pkg::CH_J) begin
                state_nxt = S_SCAN;
              end
            end else if (32'(pcnt_r) < PARAM_DEPTH) begin
              pwe = 1'b1;
              pcnt_nxt = pcnt_r + PW'(1);
            end
          end else if (b == att_pkg::CH_BEL) begin
            res_nxt.beep = 1'b1;
          end else if (b == att_pkg::CH_CR) begin
            col_nxt = '0;
          end else if (b == att_pkg::CH_LF) begin
            col_nxt = '0;
            if (32'(row_r) == ROWS - 1) begin
              res_nxt.scrolled = 1'b1;
              addr_nxt = AW'(COLUMNS);
              state_nxt = S_SCRR;
            end else begin
              row_nxt = row_r + RW'(1);
            end
          end else begin
            // Backspace steps left first and blanks the cell it lands on.
            we = 1'b1;
            res_nxt.wrote_cell = 1'b1;
            res_nxt.written_row = 5'(row_r);
            if (b == att_pkg::CH_BS) begin
              wdata = {bg_r, fg_r, att_pkg::CH_SPACE};
              waddr = (col_r != '0) ? AW'(lin - 12'd1) : AW'(lin);
              res_nxt.written_column = 7'((col_r != '0) ? col_r - CW'(1) : col_r);
              if (col_r != '0) begin
                col_nxt = col_r - CW'(1);
              end
            end else begin
              wdata = {bg_r, fg_r, b};
              waddr = AW'(lin);
              res_nxt.written_column = 7'(col_r);
              if (32'(col_r) == COLUMNS - 1) begin
                col_nxt = '0;
                if (32'(row_r) == ROWS - 1) begin
                  res_nxt.scrolled = 1'b1;
                  addr_nxt = AW'(COLUMNS);
                  state_nxt = S_SCRR;
                end else begin
                  row_nxt = row_r + RW'(1);
                end
              end else begin
                col_nxt = col_r + CW'(1);
              end
            end
            res_nxt.written_word = wdata;
          end
        end
      end
      S_SCRR: begin
        // Read the cell one row down, then write it one row up.
        if (32'(addr_r) >= CELLS) begin
          addr_nxt = AW'(CELLS - COLUMNS);
          fill_home_nxt = 1'b0;
          state_nxt = S_FILL;
        end else begin
          state_nxt = S_SCRW;
        end
      end
      S_SCRW: begin
        we = 1'b1;
        waddr = AW'(addr_r - AW'(COLUMNS));
        wdata = rdata;
        addr_nxt = addr_r + AW'(1);
        state_nxt = S_SCRR;
      end
      S_FILL: begin
        we = 1'b1;
        addr_nxt = addr_r + AW'(1);
        if (32'(addr_r) == CELLS - 1) begin
          state_nxt = S_OUT;
          if (fill_home_r) begin
            row_nxt = '0;
            col_nxt = '0;
          end
        end
      end
      S_SCAN: begin
        if (pidx_r == pcnt_r || jdone_r) begin
          state_nxt = S_OUT;
          if (b == att_pkg::CH_M) begin
            do_sgr = has_r && !bad_r;
          end else if (has_r && !bad_r && code_r == 8'd2) begin
            res_nxt.cleared = 1'b1;
            addr_nxt = '0;
            fill_home_nxt = 1'b1;
            state_nxt = S_FILL;
          end
        end else begin
          pidx_nxt = pidx_r + PW'(1);
          if (pb == att_pkg::CH_SEMI) begin
            if (b == att_pkg::CH_M) begin
              do_sgr = !bad_r;
              code_nxt = '0; has_nxt = 1'b0; bad_nxt = 1'b0;
            end else begin
              jdone_nxt = 1'b1;
            end
          end else if (pb >= 8'h30 && pb <= 8'h39) begin
            has_nxt = 1'b1;
            code_nxt = dsat;
          end else begin
            if (b == att_pkg::CH_M) begin
              has_nxt = 1'b1;
            end
            bad_nxt = 1'b1;
          end
        end
        if (do_sgr) begin
          fg_nxt = sfg;
          bg_nxt = sbg;
        end
      end
      S_OUT: begin
        if (!ovalid_r || out_ready) begin
          res_nxt.cursor_row = 5'(row_r);
          res_nxt.cursor_column = 7'(col_r);
          ovalid_nxt = 1'b1;
          ld_out = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;  addr_r <= '0;  col_r <= '0;  row_r <= '0;
      fg_r <= 4'd7;  bg_r <= 4'd0;  dfg_r <= 4'd7;  dbg_r <= 4'd0;
      esc_r <= 1'b0;  csi_r <= 1'b0;  pcnt_r <= '0;  pidx_r <= '0;
      code_r <= '0;  has_r <= 1'b0;  bad_r <= 1'b0;  jdone_r <= 1'b0;
      fill_home_r <= 1'b0;  ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;  addr_r <= addr_nxt;  col_r <= col_nxt;  row_r <= row_nxt;
      fg_r <= fg_nxt;  bg_r <= bg_nxt;  esc_r <= esc_nxt;  csi_r <= csi_nxt;
      pcnt_r <= pcnt_nxt;  pidx_r <= pidx_nxt;  code_r <= code_nxt;
      has_r <= has_nxt;  bad_r <= bad_nxt;  jdone_r <= jdone_nxt;
      fill_home_r <= fill_home_nxt;  ovalid_r <= ovalid_nxt;
      if (cfg_valid) begin
        if (cfg_index == att_pkg::CFG_FG) begin
          dfg_r <= cfg_wdata;
        end else begin
          dbg_r <= cfg_wdata;
        end
      end
    end
  end

`ifndef ASSERT_OFF
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(col_r) < COLUMNS) && (32'(row_r) < ROWS))
    else $error("cursor out of range");
  a_take_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second word taken while busy");
  a_pcount: assert property (@(posedge clk) disable iff (!rst_n)
    32'(pcnt_r) <= PARAM_DEPTH)
    else $error("parameter count overflow");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("result changed while stalled");
`endif

endmodule
`default_nettype wire

FILE: test/tb_ansi_text_terminal.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_ansi_text_terminal: self-checking bench for the text terminal
// Feeds a short table of directed bytes and reads, then phrases of random
// text, control bytes and CSI sequences under several default colours.
// A behavioral screen model predicts results (typed table rows give their own),
// each compared field by field while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_ansi_text_terminal;
  import att_pkg::*;

  localparam int COLS  = 80;
  localparam int LINES = 25;
  localparam int DEPTH = 15;
  localparam int CELLS = COLS * LINES;

  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t want;
  } dir_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic      cfg_index;
  logic [3:0] cfg_wdata;

  ansi_text_terminal i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Screen model state.
  logic [15:0] screen[0:CELLS-1];
  logic [6:0]  cur_col;
  logic [4:0]  cur_line;
  logic [3:0]  cur_fg, cur_bg, dflt_fg, dflt_bg;
  logic        esc_seen, csi_open;
  logic [7:0]  csi_bytes[0:DEPTH-1];
  int          csi_len;

  out_item_t   result_fifo[$];
  in_item_t    stim_q[$];
  dir_row_t    dir_tab[$];
  int          mismatches;
  int          sent_words;
  int          burst_left;
  logic        drv_typed;
  out_item_t   drv_want;
  logic        hold_off;
  int          stall_mode;
  int          mode_cnt;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #400_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic [15:0] cell_of(input logic [7:0] ch);
    return {cur_bg, cur_fg, ch};
  endfunction

  function automatic logic [3:0] vga_of(input int idx);
    logic [3:0] map[16] = '{4'd0, 4'd4, 4'd2, 4'd6, 4'd1, 4'd5, 4'd3, 4'd7,
                            4'd8, 4'd12, 4'd10, 4'd14, 4'd9, 4'd13, 4'd11, 4'd15};
    return map[idx];
  endfunction

  task automatic model_reset();
    for (int i = 0; i < CELLS; i++) screen[i] = 16'h0720;
    cur_col = '0; cur_line = '0;
    cur_fg = 4'd7; cur_bg = 4'd0; dflt_fg = 4'd7; dflt_bg = 4'd0;
    esc_seen = 1'b0; csi_open = 1'b0; csi_len = 0;
  endtask

  task automatic apply_sgr(input int code);
    logic [3:0] t;
    if (code == 0 || code == 27) begin
      cur_fg = dflt_fg; cur_bg = dflt_bg;
    end else if (code == 7) begin
      t = cur_fg; cur_fg = cur_bg; cur_bg = t;
    end else if (code >= 30 && code <= 37) cur_fg = vga_of(code - 30);
    else if (code >= 40 && code <= 47) cur_bg = vga_of(code - 40);
    else if (code >= 90 && code <= 97) cur_fg = vga_of(code - 82);
    else if (code >= 100 && code <= 107) cur_bg = vga_of(code - 92);
  endtask

  task automatic next_line(inout out_item_t r);
    cur_col = '0;
    if (cur_line == LINES - 1) begin
      for (int i = 0; i < CELLS - COLS; i++) screen[i] = screen[i + COLS];
      for (int i = CELLS - COLS; i < CELLS; i++) screen[i] = cell_of(CH_SPACE);
      r.scrolled = 1'b1;
    end else begin
      cur_line = cur_line + 1'b1;
    end
  endtask

  task automatic draw_cell(input logic [7:0] ch, inout out_item_t r);
    logic [15:0] w;
    w = cell_of(ch);
    screen[cur_line * COLS + cur_col] = w;
    r.wrote_cell = 1'b1; r.written_word = w;
    r.written_row = cur_line; r.written_column = cur_col;
  endtask

  // Ends a control sequence: SGR colours for m, the full-screen clear for 2J.
  task automatic close_csi(input logic [7:0] fin, inout out_item_t r);
    int code;
    bit has, bad;
    logic [7:0] b;
    code = 0; has = 0; bad = 0;
    if (fin == CH_M) begin
      if (csi_len == 0) apply_sgr(0);
      else begin
        for (int i = 0; i < csi_len; i++) begin
          b = csi_bytes[i];
          if (b == CH_SEMI) begin
            if (!bad) apply_sgr(code);
            code = 0; has = 0; bad = 0;
          end else if (b >= "0" && b <= "9") begin
            has = 1; code = code * 10 + (b - "0");
            if (code > 255) code = 255;
          end else begin
            has = 1; bad = 1;
          end
        end
        if (has && !bad) apply_sgr(code);
      end
    end else if (fin == CH_J) begin
      for (int i = 0; i < csi_len; i++) begin
        b = csi_bytes[i];
        if (b == CH_SEMI) break;
        if (b >= "0" && b <= "9") begin
          has = 1; code = code * 10 + (b - "0");
          if (code > 255) code = 255;
        end else bad = 1;
      end
      if (has && !bad && code == 2) begin
        for (int i = 0; i < CELLS; i++) screen[i] = cell_of(CH_SPACE);
        cur_col = '0; cur_line = '0;
        r.cleared = 1'b1;
      end
    end
    csi_open = 1'b0; esc_seen = 1'b0;
  endtask

  task automatic terminal_step(input in_item_t it, output out_item_t r);
    logic [7:0] c;
    r = '0;
    c = it.data_byte;
    if (it.cmd) begin
      if (it.read_row < LINES && it.read_column < COLS)
        r.read_word = screen[it.read_row * COLS + it.read_column];
    end else if (c == CH_LBRK && esc_seen) begin
      csi_open = 1'b1; esc_seen = 1'b0; csi_len = 0;
    end else if (c == CH_ESC) begin
      esc_seen = 1'b1;
    end else begin
      esc_seen = 1'b0;
      if (csi_open) begin
        if (c >= FINAL_LO && c <= FINAL_HI) close_csi(c, r);
        else if (csi_len < DEPTH) begin
          csi_bytes[csi_len] = c; csi_len++;
        end
      end else if (c == CH_BEL) r.beep = 1'b1;
      else if (c == CH_CR) cur_col = '0;
      else if (c == CH_LF) next_line(r);
      else if (c == CH_BS) begin
        if (cur_col != 0) cur_col = cur_col - 1'b1;
        draw_cell(CH_SPACE, r);
      end else begin
        draw_cell(c, r);
        if (cur_col == COLS - 1) next_line(r);
        else cur_col = cur_col + 1'b1;
      end
    end
    r.cursor_row = cur_line; r.cursor_column = cur_col;
  endtask

  function automatic string bad_fields(input out_item_t e, input out_item_t a);
    string s;
    s = "";
    if (e.wrote_cell !== a.wrote_cell) s = {s, " wrote_cell"};
    if (e.written_word !== a.written_word) s = {s, " written_word"};
    if (e.written_row !== a.written_row) s = {s, " written_row"};
    if (e.written_column !== a.written_column) s = {s, " written_column"};
    if (e.scrolled !== a.scrolled) s = {s, " scrolled"};
    if (e.cleared !== a.cleared) s = {s, " cleared"};
    if (e.beep !== a.beep) s = {s, " beep"};
    if (e.cursor_row !== a.cursor_row) s = {s, " cursor_row"};
    if (e.cursor_column !== a.cursor_column) s = {s, " cursor_column"};
    if (e.read_word !== a.read_word) s = {s, " read_word"};
    return s;
  endfunction

  task automatic note_error(input string msg);
    if (mismatches < 10) $display("mismatch: %s", msg);
    mismatches++;
  endtask

  // Prediction on input acceptance, checking on output acceptance.
  always @(posedge clk) begin
    out_item_t r;
    string s;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_FG) dflt_fg = cfg_wdata;
        else dflt_bg = cfg_wdata;
      end
      if (in_valid && in_ready) begin
        terminal_step(in_data, r);
        result_fifo.push_back(drv_typed ? drv_want : r);
        sent_words++;
      end
      if (out_valid && out_ready) begin
        if (result_fifo.size() == 0) note_error($sformatf("unexpected word %h", out_data));
        else begin
          r = result_fifo.pop_front();
          s = bad_fields(r, out_data);
          if (s != "") note_error($sformatf("%s exp %h got %h", s, r, out_data));
        end
      end
    end
  end

  // Receiver: stall pattern redrawn periodically, plus one long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      mode_cnt <= 0;
      stall_mode <= 0;
    end else begin
      mode_cnt <= mode_cnt + 1;
      if (mode_cnt % 256 == 255) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        0: out_ready <= !hold_off;
        1: out_ready <= !hold_off && ($urandom_range(0, 1) == 0);
        default: out_ready <= !hold_off && ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  initial begin
    hold_off = 1'b0;
    wait (sent_words >= 500);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (3000) @(posedge clk);
    hold_off <= 1'b0;
  end

  task automatic send_word(input in_item_t it, input logic typed, input out_item_t want);
    in_valid <= 1'b1;
    in_data <= it;
    drv_typed <= typed;
    drv_want <= want;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
  endtask

  task automatic write_reg(input logic idx, input logic [3:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic in_item_t feed(input logic [7:0] b);
    return {1'b0, b, 5'($urandom), 7'($urandom)};
  endfunction

  function automatic in_item_t peek(input logic [4:0] row, input logic [6:0] col);
    return {1'b1, 8'($urandom), row, col};
  endfunction

  function automatic out_item_t mk_out(input logic wc, input logic [15:0] ww,
                                       input logic [6:0] wcol, input logic bp,
                                       input logic [6:0] ccol, input logic [15:0] rw);
    out_item_t r;
    r = '0;
    r.wrote_cell = wc; r.written_word = ww; r.written_column = wcol;
    r.beep = bp; r.cursor_column = ccol; r.read_word = rw;
    return r;
  endfunction

  function automatic dir_row_t plain(input in_item_t it);
    return {it, 1'b0, out_item_t'('0)};
  endfunction

  task automatic push_text(input string s);
    foreach (s[i]) stim_q.push_back(feed(s[i]));
  endtask

  function automatic int sgr_code();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 7;
      2: return 27;
      3: return $urandom_range(30, 37);
      4: return $urandom_range(40, 47);
      5: return $urandom_range(90, 97);
      6: return $urandom_range(100, 107);
      7: return $urandom_range(0, 999);
      default: return $urandom_range(0, 120);
    endcase
  endfunction

  task automatic gen_phrase();
    int r, n;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      n = $urandom_range(1, 12);
      repeat (n) stim_q.push_back(feed(8'($urandom_range(8'h20, 8'h7E))));
    end else if (r < 53) begin
      case ($urandom_range(0, 3))
        0: stim_q.push_back(feed(CH_CR));
        1: stim_q.push_back(feed(CH_LF));
        2: stim_q.push_back(feed(CH_BS));
        default: stim_q.push_back(feed(CH_BEL));
      endcase
    end else if (r < 58) begin
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 7) == 0) stim_q.push_back(peek(5'($urandom), 7'($urandom)));
        else stim_q.push_back(peek(5'($urandom_range(0, 24)), 7'($urandom_range(0, 79))));
      end
    end else if (r < 78) begin
      stim_q.push_back(feed(CH_ESC)); stim_q.push_back(feed(CH_LBRK));
      n = $urandom_range(0, 4);
      for (int i = 0; i < n; i++) begin
        if (i > 0) stim_q.push_back(feed(CH_SEMI));
        case ($urandom_range(0, 11))
          0: ;
          1: push_text($sformatf(":%0d", sgr_code()));
          default: push_text($sformatf("%0d", sgr_code()));
        endcase
      end
      if ($urandom_range(0, 6) == 0) stim_q.push_back(feed(CH_SEMI));
      stim_q.push_back(feed(CH_M));
    end else if (r < 80) begin
      stim_q.push_back(feed(CH_ESC)); stim_q.push_back(feed(CH_LBRK));
      case ($urandom_range(0, 6))
        0: ;
        1: push_text("02");
        2: push_text("2;5");
        3: push_text("3");
        4: push_text("2x");
        default: push_text("2");
      endcase
      stim_q.push_back(feed(CH_J));
    end else if (r < 84) begin
      stim_q.push_back(feed(CH_ESC)); stim_q.push_back(feed(CH_LBRK));
      push_text($sformatf("%0d", $urandom_range(0, 9)));
      stim_q.push_back(feed(8'($urandom_range(FINAL_LO, FINAL_HI))));
    end else if (r < 88) begin
      stim_q.push_back(feed(CH_ESC));
      stim_q.push_back(feed(8'($urandom_range(0, 255))));
    end else if (r < 91) begin
      // A second ESC [ starts the sequence over.
      push_text({8'h1B, "[31", 8'h1B, 8'h1B, "[4"});
      stim_q.push_back(feed(CH_M));
    end else if (r < 93) begin
      stim_q.push_back(feed(CH_ESC)); stim_q.push_back(feed(CH_LBRK));
      repeat ($urandom_range(16, 24))
        stim_q.push_back(feed($urandom_range(0, 4) == 0 ? CH_SEMI
                                                         : 8'($urandom_range("0", "9"))));
      stim_q.push_back(feed(CH_M));
    end else if (r < 98) begin
      stim_q.push_back(feed(8'($urandom_range(0, 255))));
    end else begin
      stim_q.push_back(feed(CH_ESC)); stim_q.push_back(feed(CH_LBRK));
      repeat ($urandom_range(1, 5))
        stim_q.push_back(feed($urandom_range(0, 1) ? 8'($urandom_range(8'h20, 8'h3F))
                                                    : 8'($urandom_range(8'h80, 8'hFF))));
      stim_q.push_back(feed(CH_M));
    end
  endtask

  // The extra edge lets the monitor record the last word before the wait.
  task automatic drain();
    @(posedge clk);
    wait (result_fifo.size() == 0);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    logic [3:0] fg_set[4];
    logic [3:0] bg_set[4];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_FG;
    cfg_wdata = '0;
    drv_typed = 1'b0;
    drv_want = '0;
    mismatches = 0;
    sent_words = 0;
    burst_left = 1;
    model_reset();
    fg_set = '{4'd7, 4'd15, 4'd0, 4'($urandom)};
    bg_set = '{4'd0, 4'd15, 4'd0, 4'($urandom)};
    dir_tab = '{
      {peek(5'd0, 7'd0), 1'b1, mk_out(1'b0, 16'h0, 7'd0, 1'b0, 7'd0, 16'h0720)},
      {peek(5'd31, 7'd127), 1'b1, mk_out(1'b0, 16'h0, 7'd0, 1'b0, 7'd0, 16'h0000)},
      {peek(5'd24, 7'd79), 1'b1, mk_out(1'b0, 16'h0, 7'd0, 1'b0, 7'd0, 16'h0720)},
      {feed(CH_BEL), 1'b1, mk_out(1'b0, 16'h0, 7'd0, 1'b1, 7'd0, 16'h0)},
      {feed(8'h41), 1'b1, mk_out(1'b1, 16'h0741, 7'd0, 1'b0, 7'd1, 16'h0)},
      plain(feed(8'hFF)), plain(feed(8'h00)), plain(feed(CH_BS)), plain(feed(CH_CR)),
      plain(feed(CH_LF)), plain(feed(CH_ESC)), plain(feed("x")), plain(feed(CH_ESC)),
      plain(feed(CH_LBRK)), plain(feed("9")), plain(feed("1")), plain(feed(CH_SEMI)),
      plain(feed("4")), plain(feed("2")), plain(feed(CH_M)), plain(feed(CH_ESC)),
      plain(feed(CH_LBRK)), plain(feed("2")), plain(feed(CH_J))
    };
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(CFG_FG, fg_set[ph]);
      write_reg(CFG_BG, bg_set[ph]);
      if (ph == 0)
        foreach (dir_tab[i]) send_word(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].want);
      while (stim_q.size() < 400) gen_phrase();
      while (stim_q.size() > 0) send_word(stim_q.pop_front(), 1'b0, '0);
      in_valid <= 1'b0;
      drain();
    end
    repeat (50) @(posedge clk);
    if (mismatches == 0 && result_fifo.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
